// File: rtl/core/mpfm_pkg.sv
// Shared types, register indexes and constants for the multi-pattern first-match core.
package mpfm_pkg;

  localparam int NUM_PATTERNS_DEF    = 4;
  localparam int MAX_PATTERN_LEN_DEF = 8;
  localparam int INDEX_WIDTH_DEF     = 16;

  localparam int PATTERN_WIDTH      = 64;
  localparam int LENGTH_FIELD_WIDTH = 4;
  localparam int LENGTHS_WIDTH      = 16;
  localparam int COUNT_WIDTH        = 3;
  localparam int CFG_INDEX_WIDTH    = 3;
  localparam int CFG_DATA_WIDTH     = 64;
  localparam int BYTE_WIDTH         = 8;
  localparam int MATCH_INDEX_WIDTH  = 16;
  localparam int PATTERN_NUM_WIDTH  = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_ZERO    = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_ONE     = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_TWO     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_THREE   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_LENGTHS = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_COUNT   = 3'd5;

  localparam logic [LENGTHS_WIDTH-1:0] LENGTHS_RESET = 16'h1111;
  localparam logic [COUNT_WIDTH-1:0]   COUNT_RESET   = 3'd1;

  typedef struct packed {
    logic [BYTE_WIDTH-1:0] data_byte;
    logic                  last_byte;
  } item_t;

  typedef struct packed {
    logic                         found;
    logic [MATCH_INDEX_WIDTH-1:0] match_index;
    logic [PATTERN_NUM_WIDTH-1:0] pattern_number;
  } result_t;

endpackage

// File: rtl/core/mpfm_match.sv
// Parallel compare of every enabled pattern against the newest bytes of the window.
module mpfm_match #(
  parameter int NUM_PATTERNS    = mpfm_pkg::NUM_PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = mpfm_pkg::MAX_PATTERN_LEN_DEF,
  parameter int FILL_WIDTH      = $clog2(MAX_PATTERN_LEN + 1)
) (
  input  logic [NUM_PATTERNS-1:0][mpfm_pkg::PATTERN_WIDTH-1:0] patterns,
  input  logic [mpfm_pkg::LENGTHS_WIDTH-1:0]                   lengths,
  input  logic [mpfm_pkg::COUNT_WIDTH-1:0]                     count,
  input  logic [mpfm_pkg::BYTE_WIDTH*MAX_PATTERN_LEN-1:0]      window,
  input  logic [FILL_WIDTH-1:0]                                fill,
  output logic [NUM_PATTERNS-1:0]                              hit
);
  import mpfm_pkg::*;

  always_comb begin
    logic [LENGTH_FIELD_WIDTH-1:0] len;
    logic                          same;
    hit = '0;
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      len = lengths[LENGTH_FIELD_WIDTH*k +: LENGTH_FIELD_WIDTH];
      for (int l = 1; l <= MAX_PATTERN_LEN; l++) begin
        same = 1'b1;
        for (int j = 0; j < l; j++) begin
          if (patterns[k][BYTE_WIDTH*j +: BYTE_WIDTH] !=
              window[BYTE_WIDTH*(l-1-j) +: BYTE_WIDTH]) begin
            same = 1'b0;
          end
        end
        if (same && len == LENGTH_FIELD_WIDTH'(l) && COUNT_WIDTH'(k) < count &&
            FILL_WIDTH'(l) <= fill) begin
          hit[k] = 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/multi_pattern_first_match_core.sv
// Top level of the multi-pattern first-match core: config registers, string state, result.
// Bytes of a string stream in one per clock, the final one marked by last_byte. Each
// accepted word is registered, then compared in a single pass against up to
// NUM_PATTERNS patterns of 1 to MAX_PATTERN_LEN bytes, and the earliest match start
// (lowest pattern number on a tie) is kept. The last byte produces one result word with
// the found flag, start offset and pattern number, and clears the per-string state.
// Throughput is one byte per cycle unless stalled; the result word is registered from the
// input register. The input register advances while a result waits, so only a last byte
// that meets a full, stalled result register holds the input side. Patterns must be
// written through the plain write port while the core is idle; not enforced by the block.
module multi_pattern_first_match_core #(
  parameter int NUM_PATTERNS    = mpfm_pkg::NUM_PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = mpfm_pkg::MAX_PATTERN_LEN_DEF,
  parameter int INDEX_WIDTH     = mpfm_pkg::INDEX_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [mpfm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [mpfm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  logic                                   item_valid,
  output logic                                   item_ready,
  input  mpfm_pkg::item_t                        item,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output mpfm_pkg::result_t                      result
);
  import mpfm_pkg::*;

  localparam int FILL_WIDTH = $clog2(MAX_PATTERN_LEN + 1);
  localparam int WIN_WIDTH  = BYTE_WIDTH * MAX_PATTERN_LEN;
  localparam int IDX_WIDTH  = INDEX_WIDTH + 1;
  localparam logic [INDEX_WIDTH-1:0] POS_LIMIT = {INDEX_WIDTH{1'b1}};

  logic [NUM_PATTERNS-1:0][PATTERN_WIDTH-1:0] patterns;
  logic [LENGTHS_WIDTH-1:0]                   lengths;
  logic [COUNT_WIDTH-1:0]                     count;

  logic                         stage_valid;
  item_t                        stage;
  logic                         advance;

  logic [WIN_WIDTH-1:0]         window;
  logic [WIN_WIDTH-1:0]         window_next;
  logic [FILL_WIDTH-1:0]        fill;
  logic [FILL_WIDTH-1:0]        fill_next;
  logic [INDEX_WIDTH-1:0]       position;
  logic [FILL_WIDTH-1:0]        beyond;
  logic [INDEX_WIDTH-1:0]       best_start;
  logic [INDEX_WIDTH-1:0]       best_start_next;
  logic [PATTERN_NUM_WIDTH-1:0] best_pattern;
  logic [PATTERN_NUM_WIDTH-1:0] best_pattern_next;
  logic                         have_match;
  logic                         have_match_next;
  logic [NUM_PATTERNS-1:0]      hit;

  // config registers
  for (genvar k = 0; k < NUM_PATTERNS; k++) begin : g_pattern
    always_ff @(posedge clk) begin
      if (rst) begin
        patterns[k] <= '0;
      end else if (cfg_we && cfg_index == REG_PATTERN_ZERO + CFG_INDEX_WIDTH'(k)) begin
        patterns[k] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lengths <= LENGTHS_RESET;
      count   <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTHS: lengths <= cfg_data[LENGTHS_WIDTH-1:0];
        REG_PATTERN_COUNT:   count   <= cfg_data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign advance    = stage_valid && (!stage.last_byte || !result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage <= item;
    end
  end

  // match pass
  assign window_next = WIN_WIDTH'({window, stage.data_byte});
  assign fill_next   = (fill == FILL_WIDTH'(MAX_PATTERN_LEN)) ? fill : fill + 1'b1;

  mpfm_match #(
    .NUM_PATTERNS    (NUM_PATTERNS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .FILL_WIDTH      (FILL_WIDTH)
  ) u_match (
    .patterns (patterns),
    .lengths  (lengths),
    .count    (count),
    .window   (window_next),
    .fill     (fill_next),
    .hit      (hit)
  );

  always_comb begin
    logic [IDX_WIDTH-1:0] idx;
    logic [IDX_WIDTH-1:0] start;
    idx = IDX_WIDTH'(position) + IDX_WIDTH'(beyond);
    have_match_next   = have_match;
    best_start_next   = best_start;
    best_pattern_next = best_pattern;
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      start = idx + IDX_WIDTH'(1) -
              IDX_WIDTH'(lengths[LENGTH_FIELD_WIDTH*k +: LENGTH_FIELD_WIDTH]);
      if (hit[k] && !start[INDEX_WIDTH] &&
          (!have_match_next || start[INDEX_WIDTH-1:0] < best_start_next ||
           (start[INDEX_WIDTH-1:0] == best_start_next &&
            PATTERN_NUM_WIDTH'(k) < best_pattern_next))) begin
        have_match_next   = 1'b1;
        best_start_next   = start[INDEX_WIDTH-1:0];
        best_pattern_next = PATTERN_NUM_WIDTH'(k);
      end
    end
  end

  // per-string state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      position     <= '0;
      beyond       <= '0;
      have_match   <= 1'b0;
      best_start   <= '0;
      best_pattern <= '0;
    end else if (advance) begin
      if (stage.last_byte) begin
        fill         <= '0;
        position     <= '0;
        beyond       <= '0;
        have_match   <= 1'b0;
        best_start   <= '0;
        best_pattern <= '0;
      end else begin
        fill         <= fill_next;
        have_match   <= have_match_next;
        best_start   <= best_start_next;
        best_pattern <= best_pattern_next;
        if (position != POS_LIMIT) begin
          position <= position + 1'b1;
        end else if (beyond != FILL_WIDTH'(MAX_PATTERN_LEN)) begin
          beyond <= beyond + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      window <= window_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && stage.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.last_byte) begin
      result.found          <= have_match_next;
      result.match_index    <= have_match_next ? MATCH_INDEX_WIDTH'(best_start_next) : '0;
      result.pattern_number <= have_match_next ? best_pattern_next : '0;
    end
  end

endmodule

// File: rtl/core/mpfm_checker.sv
// Port-level checker for the multi-pattern first-match core, bound to the top level.
module mpfm_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input mpfm_pkg::result_t result
);
  import mpfm_pkg::*;

  // hold a stalled result word
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // drop no result after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid)
    else $error("input stalled with no result waiting");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.match_index == '0 &&
                                      result.pattern_number == '0)
    else $error("nonzero index or pattern without a match");

  a_stall_last: assert property (@(posedge clk) disable iff (rst)
    !item_ready |=> $past(result_valid && !result_ready))
    else $error("input stalled without a blocked result");

endmodule

bind multi_pattern_first_match_core mpfm_checker u_checker (.*);

// File: tb/mpfm_match_checker.sv
// Checker for the multi-pattern first-match core: watches config and both channels, predicts, compares.
`timescale 1ns / 1ps
module mpfm_match_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mpfm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mpfm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 item_valid,
  input  logic                                 item_ready,
  input  mpfm_pkg::item_t                      item,
  input  logic                                 result_valid,
  input  logic                                 result_ready,
  input  mpfm_pkg::result_t                    result,
  output int                                   outstanding,
  output int                                   errors
);
  import mpfm_pkg::*;

  localparam int unsigned POS_LIMIT = (1 << INDEX_WIDTH_DEF) - 1;

  logic [PATTERN_WIDTH-1:0] pat_cfg [NUM_PATTERNS_DEF];
  logic [LENGTHS_WIDTH-1:0] len_cfg;
  logic [COUNT_WIDTH-1:0]   cnt_cfg;

  logic [PATTERN_WIDTH-1:0] window;
  int unsigned              fill;
  int unsigned              pos;
  int unsigned              over;
  int unsigned              best_start;
  int unsigned              best_pat;
  logic                     have;

  result_t expected_results [$];
  result_t want;
  int      waiting    = 0;
  int      fail_count = 0;

  assign outstanding = waiting;
  assign errors      = fail_count;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (fail_count < 40)
      $display("t=%0t %s: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
    fail_count++;
  endtask

  function automatic void clear_string();
    window     = '0;
    fill       = 0;
    pos        = 0;
    over       = 0;
    best_start = 0;
    best_pat   = 0;
    have       = 1'b0;
  endfunction

  function automatic void scan_byte(input item_t w);
    int unsigned idx;
    int unsigned n;
    int unsigned plen;
    int unsigned start;
    logic        hit;
    result_t     r;
    idx    = pos + over;
    window = {window[PATTERN_WIDTH-BYTE_WIDTH-1:0], w.data_byte};
    if (fill < MAX_PATTERN_LEN_DEF) fill++;
    n = (cnt_cfg > NUM_PATTERNS_DEF) ? NUM_PATTERNS_DEF : cnt_cfg;
    for (int k = 0; k < n; k++) begin
      plen = len_cfg[LENGTH_FIELD_WIDTH*k +: LENGTH_FIELD_WIDTH];
      if (plen != 0 && plen <= MAX_PATTERN_LEN_DEF && plen <= fill) begin
        start = idx + 1 - plen;
        hit   = (start <= POS_LIMIT);
        for (int j = 0; j < plen; j++) begin
          if (pat_cfg[k][8*j +: 8] != window[8*(plen-1-j) +: 8]) hit = 1'b0;
        end
        if (hit && (!have || start < best_start || (start == best_start && k < best_pat))) begin
          have       = 1'b1;
          best_start = start;
          best_pat   = k;
        end
      end
    end
    if (pos < POS_LIMIT) pos++;
    else if (over < MAX_PATTERN_LEN_DEF) over++;
    if (w.last_byte) begin
      r.found          = have;
      r.match_index    = have ? best_start[MATCH_INDEX_WIDTH-1:0] : '0;
      r.pattern_number = have ? best_pat[PATTERN_NUM_WIDTH-1:0] : '0;
      expected_results.push_back(r);
      clear_string();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (pat_cfg[k]) pat_cfg[k] = '0;
      len_cfg = LENGTHS_RESET;
      cnt_cfg = COUNT_RESET;
      clear_string();
      expected_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with none pending", 64'(result), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (result.found != want.found)
            report_mismatch("found", 64'(result.found), 64'(want.found));
          if (result.match_index != want.match_index)
            report_mismatch("match_index", 64'(result.match_index), 64'(want.match_index));
          if (result.pattern_number != want.pattern_number)
            report_mismatch("pattern_number", 64'(result.pattern_number),
                            64'(want.pattern_number));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_ZERO:    pat_cfg[0] = cfg_data;
          REG_PATTERN_ONE:     pat_cfg[1] = cfg_data;
          REG_PATTERN_TWO:     pat_cfg[2] = cfg_data;
          REG_PATTERN_THREE:   pat_cfg[3] = cfg_data;
          REG_PATTERN_LENGTHS: len_cfg    = cfg_data[LENGTHS_WIDTH-1:0];
          REG_PATTERN_COUNT:   cnt_cfg    = cfg_data[COUNT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) scan_byte(item);
    end
    waiting <= expected_results.size();
  end

endmodule

// File: tb/tb_multi_pattern_first_match_core.sv
// Testbench top for the multi-pattern first-match core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_multi_pattern_first_match_core;
  import mpfm_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_SIX   = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_SEVEN = 3'd7;
  localparam int IDLE_LIMIT    = 1000;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_ITEMS    = 300;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       cfg_we       = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data     = '0;
  logic                       item_valid   = 1'b0;
  logic                       item_ready;
  item_t                      item         = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  result_t                    result;

  int   outstanding;
  int   errors;
  int   quiet_cycles = 0;
  int   stall_left   = 0;
  int   open_left    = 0;
  int   send_run     = 0;
  logic no_idle      = 1'b0;

  logic [PATTERN_WIDTH-1:0] pat_m [NUM_PATTERNS_DEF];
  logic [LENGTHS_WIDTH-1:0] lens_m;
  logic [7:0]               str_q [$];

  multi_pattern_first_match_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  mpfm_match_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .outstanding  (outstanding),
    .errors       (errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (no_idle) begin
      result_ready <= 1'b1;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (open_left > 0) begin
      result_ready <= 1'b1;
      open_left    <= open_left - 1;
    end else begin
      result_ready <= 1'b1;
      open_left    <= $urandom_range(0, 40);
      stall_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_patterns(input logic [63:0] p0, input logic [63:0] p1,
                              input logic [63:0] p2, input logic [63:0] p3,
                              input logic [63:0] lens_word, input logic [63:0] cnt_word);
    pat_m[0] = p0;
    pat_m[1] = p1;
    pat_m[2] = p2;
    pat_m[3] = p3;
    lens_m   = lens_word[LENGTHS_WIDTH-1:0];
    write_reg(REG_PATTERN_ZERO, p0);
    write_reg(REG_PATTERN_ONE, p1);
    write_reg(REG_PATTERN_TWO, p2);
    write_reg(REG_PATTERN_THREE, p3);
    write_reg(REG_PATTERN_LENGTHS, lens_word);
    write_reg(REG_PATTERN_COUNT, cnt_word);
  endtask

  // Hold valid until the word is taken; drop it only across a gap.
  task automatic send_word(input logic [7:0] b, input logic l);
    item_t w;
    int    gap;
    gap = 0;
    if (!no_idle) begin
      if (send_run > 0) begin
        send_run--;
      end else begin
        send_run = $urandom_range(0, 40);
        if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 14);
      end
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.data_byte = b;
    w.last_byte = l;
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic send_string();
    foreach (str_q[i]) send_word(str_q[i], i == str_q.size() - 1);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [63:0] p [NUM_PATTERNS_DEF];
    logic [63:0] lw;
    logic [63:0] cw;
    logic [7:0]  alpha_a;
    logic [7:0]  alpha_b;
    logic        narrow;
    int          sent;
    int          phase;
    int          phase_target;
    int          phase_sent;
    int          slen;
    int          sel;
    int          k;
    int          plen;
    int          cut;

    pat_m[0] = '0;
    pat_m[1] = '0;
    pat_m[2] = '0;
    pat_m[3] = '0;
    lens_m   = LENGTHS_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    str_q = '{8'hFF};
    send_string();
    str_q = '{8'hFF, 8'h00};
    send_string();
    wait_idle();

    // tie at the same start, count above the pattern total, disabled long pattern
    set_patterns('1, 64'h0, 64'h0, 64'h0123, 64'h9228, 64'd7);
    str_q = '{8'h00, 8'h00};
    send_string();
    str_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_string();
    wait_idle();

    write_reg(REG_UNUSED_SIX, {$urandom, $urandom});
    write_reg(REG_UNUSED_SEVEN, {$urandom, $urandom});
    set_patterns('1, 64'h0, 64'h0, 64'h0123, 64'h9228, 64'd0);
    str_q = '{8'h00, 8'h00, 8'h00};
    send_string();
    wait_idle();

    set_patterns('1, 64'h0, 64'h0, 64'h0123, 64'h9228, 64'd4);
    str_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_string();
    wait_idle();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (RANDOM_ITEMS - sent <= TAIL_ITEMS) no_idle <= 1'b1;
      if (phase == 0) begin
        set_patterns('1, '1, '1, '1, 64'h8888, 64'd4);
      end else if (phase == 1) begin
        set_patterns('0, '0, '0, '0, 64'hFFFF, 64'd7);
      end else begin
        alpha_a = 8'($urandom);
        alpha_b = 8'($urandom);
        narrow  = 1'($urandom_range(0, 1));
        for (int i = 0; i < NUM_PATTERNS_DEF; i++) begin
          for (int j = 0; j < 8; j++) begin
            if (narrow && $urandom_range(0, 3) != 0)
              p[i][8*j +: 8] = $urandom_range(0, 1) ? alpha_a : alpha_b;
            else
              p[i][8*j +: 8] = 8'($urandom);
          end
          if (i > 0 && $urandom_range(0, 3) == 0) p[i] = p[$urandom_range(0, i - 1)];
        end
        lw = {$urandom, $urandom};
        for (int i = 0; i < NUM_PATTERNS_DEF; i++) begin
          sel = $urandom_range(0, 9);
          if (sel < 8) lw[4*i +: 4] = 4'($urandom_range(1, 8));
          else if (sel == 8) lw[4*i +: 4] = 4'd0;
          else lw[4*i +: 4] = 4'($urandom_range(9, 15));
        end
        cw = {$urandom, $urandom};
        cw[2:0] = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) :
                                               3'($urandom_range(0, 7));
        set_patterns(p[0], p[1], p[2], p[3], lw, cw);
      end
      phase_target = $urandom_range(100, 200);
      phase_sent   = 0;
      while (phase_sent < phase_target) begin
        str_q.delete();
        slen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        while (str_q.size() < slen) begin
          sel = $urandom_range(0, 9);
          if (sel < 3) begin
            k    = $urandom_range(0, 3);
            plen = int'(lens_m[4*k +: 4]);
            if (plen == 0 || plen > 8) plen = $urandom_range(1, 8);
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, plen - 1) : plen;
            for (int j = 0; j < cut; j++) str_q.push_back(pat_m[k][8*j +: 8]);
          end else if (sel < 7) begin
            k    = $urandom_range(0, 3);
            plen = $urandom_range(0, 7);
            str_q.push_back(pat_m[k][8*plen +: 8]);
          end else begin
            str_q.push_back(8'($urandom));
          end
        end
        send_string();
        phase_sent += str_q.size();
      end
      sent += phase_sent;
      phase++;
      wait_idle();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
